// File: rtl/core/force_torque_sample_calibrator_macros.svh
// ---------------------------------------------------------------------------
// Force/torque sample calibrator assertion macros
// Short forms for the concurrent checks used across the core.
// ---------------------------------------------------------------------------
`ifndef FORCE_TORQUE_SAMPLE_CALIBRATOR_MACROS_SVH
`define FORCE_TORQUE_SAMPLE_CALIBRATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define FTSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FTSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ftsc_pkg.sv
// ---------------------------------------------------------------------------
// ftsc_pkg
// Types and constants shared by the force/torque sample calibrator core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ftsc_pkg;

  localparam int AXIS_COUNT    = 6;
  localparam int MAT_ENTRIES   = AXIS_COUNT * AXIS_COUNT;
  localparam int PAIRS_PER_ROW = AXIS_COUNT / 2;
  localparam int BIAS_IDX_W    = $clog2(AXIS_COUNT);
  localparam int INDEX_W       = 6;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int ACC_W  = PROD_W + 4;

  localparam logic [3:0] FIRST_LEN      = 4'd8;
  localparam logic [3:0] SECOND_LEN     = 4'd6;
  localparam int         STATUS_ERR_BIT = 15;

  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_LOAD_MATRIX = 2'd1,
    OP_LOAD_BIAS   = 2'd2,
    OP_UNDEF       = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RS_OK        = 2'd0,
    RS_BAD_LEN   = 2'd1,
    RS_DEV_ERR   = 2'd2,
    RS_BAD_INDEX = 2'd3
  } result_status_t;

  typedef struct packed {
    logic           sample_ok;
    result_status_t status;
    logic [15:0]    device_status;
  } ftsc_tag_t;

  typedef struct packed {
    logic               we;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  value;
  } ftsc_mload_t;

endpackage

`default_nettype wire

// File: rtl/core/ftsc_if.sv
// ---------------------------------------------------------------------------
// ftsc_if
// Valid/ready channels for sample/load words in and result words out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ftsc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [3:0]         first_frame_length;
  logic [3:0]         second_frame_length;
  logic [63:0]        first_frame_bytes;
  logic [47:0]        second_frame_bytes;
  logic [5:0]         load_index;
  logic signed [31:0] load_value;

  modport source (
    output valid, opcode, first_frame_length, second_frame_length,
           first_frame_bytes, second_frame_bytes, load_index, load_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_frame_length, second_frame_length,
           first_frame_bytes, second_frame_bytes, load_index, load_value,
    output ready
  );
endinterface

interface ftsc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_status;
  logic [15:0]        device_status;
  logic signed [31:0] axis_out_0;
  logic signed [31:0] axis_out_1;
  logic signed [31:0] axis_out_2;
  logic signed [31:0] axis_out_3;
  logic signed [31:0] axis_out_4;
  logic signed [31:0] axis_out_5;

  modport source (
    output valid, result_status, device_status, axis_out_0, axis_out_1,
           axis_out_2, axis_out_3, axis_out_4, axis_out_5,
    input  ready
  );
  modport sink (
    input  valid, result_status, device_status, axis_out_0, axis_out_1,
           axis_out_2, axis_out_3, axis_out_4, axis_out_5,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/ftsc_unpack.sv
// ---------------------------------------------------------------------------
// ftsc_unpack
// Input register, frame and load-index checks, gauge unpacking and bias subtraction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "force_torque_sample_calibrator_macros.svh"

module ftsc_unpack import ftsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  ftsc_in_if.sink                  item,
  output logic                     b_valid,
  input  logic                     b_ready,
  output ftsc_tag_t                b_tag,
  output logic signed [DATA_W-1:0] b_diff [AXIS_COUNT],
  output ftsc_mload_t              b_mload
);

  logic                     a_valid;
  logic [1:0]               a_opcode;
  logic [3:0]               a_len1;
  logic [3:0]               a_len2;
  logic [63:0]              a_f1;
  logic [47:0]              a_f2;
  logic [INDEX_W-1:0]       a_index;
  logic signed [DATA_W-1:0] a_value;

  logic a_free;
  logic b_free;

  opcode_t                  a_op;
  logic [15:0]              a_word;
  logic [15:0]              a_z    [AXIS_COUNT];
  logic [DATA_W:0]          a_wide [AXIS_COUNT];
  logic signed [DATA_W-1:0] a_diff [AXIS_COUNT];
  ftsc_tag_t                a_tag;
  logic                     a_bias_we;
  logic                     a_mload_we;

  logic signed [DATA_W-1:0] bias [AXIS_COUNT];

  assign b_free     = !b_valid || b_ready;
  assign a_free     = !a_valid || b_free;
  assign item.ready = a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_opcode <= item.opcode;
      a_len1   <= item.first_frame_length;
      a_len2   <= item.second_frame_length;
      a_f1     <= item.first_frame_bytes;
      a_f2     <= item.second_frame_bytes;
      a_index  <= item.load_index;
      a_value  <= item.load_value;
    end
  end

  assign a_op   = opcode_t'(a_opcode);
  assign a_word = a_f1[63:48];

  // interleave gauges of the two frames: g0,g3,g1,g4,g2,g5
  always_comb begin
    a_z[0] = a_f1[47:32];
    a_z[1] = a_f2[47:32];
    a_z[2] = a_f1[31:16];
    a_z[3] = a_f2[31:16];
    a_z[4] = a_f1[15:0];
    a_z[5] = a_f2[15:0];
  end

  always_comb begin
    for (int c = 0; c < AXIS_COUNT; c++) begin
      a_wide[c] = {a_z[c][15], a_z[c], 16'b0} - {bias[c][DATA_W-1], bias[c]};
      if (a_wide[c][DATA_W] != a_wide[c][DATA_W-1]) begin
        a_diff[c] = a_wide[c][DATA_W] ? DATA_MIN : DATA_MAX;
      end else begin
        a_diff[c] = a_wide[c][DATA_W-1:0];
      end
    end
  end

  always_comb begin
    a_tag      = '0;
    a_bias_we  = 1'b0;
    a_mload_we = 1'b0;
    case (a_op)
      OP_SAMPLE: begin
        if (a_len1 != FIRST_LEN || a_len2 != SECOND_LEN) begin
          a_tag.status = RS_BAD_LEN;
        end else begin
          a_tag.device_status = a_word;
          if (a_word[STATUS_ERR_BIT]) begin
            a_tag.status = RS_DEV_ERR;
          end else begin
            a_tag.status    = RS_OK;
            a_tag.sample_ok = 1'b1;
          end
        end
      end
      OP_LOAD_MATRIX: begin
        if (a_index < INDEX_W'(MAT_ENTRIES)) begin
          a_mload_we = 1'b1;
        end else begin
          a_tag.status = RS_BAD_INDEX;
        end
      end
      OP_LOAD_BIAS: begin
        if (a_index < INDEX_W'(AXIS_COUNT)) begin
          a_bias_we = 1'b1;
        end else begin
          a_tag.status = RS_BAD_INDEX;
        end
      end
      default: begin
        a_tag.status = RS_BAD_INDEX;
      end
    endcase
  end

  // bias is written as the load word leaves this stage, where samples read it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < AXIS_COUNT; c++) begin
        bias[c] <= '0;
      end
    end else if (a_valid && b_free && a_bias_we) begin
      bias[a_index[BIAS_IDX_W-1:0]] <= a_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_tag         <= a_tag;
      b_diff        <= a_diff;
      b_mload.we    <= a_mload_we;
      b_mload.index <= a_index;
      b_mload.value <= a_value;
    end
  end

  `FTSC_ASSERT_SAME(a_stall_source, clk, rst, !item.ready, a_valid && b_valid && !b_ready, "input stalled without a full downstream")

endmodule

`default_nettype wire

// File: rtl/core/ftsc_mac.sv
// ---------------------------------------------------------------------------
// ftsc_mac
// Calibration matrix store, 36 parallel products and a registered adder tree.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "force_torque_sample_calibrator_macros.svh"

module ftsc_mac import ftsc_pkg::*; #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     b_valid,
  output logic                     b_ready,
  input  ftsc_tag_t                b_tag,
  input  logic signed [DATA_W-1:0] b_diff [AXIS_COUNT],
  input  ftsc_mload_t              b_mload,
  output logic                     e_valid,
  input  logic                     e_ready,
  output ftsc_tag_t                e_tag,
  output logic signed [ACC_W-1:0]  e_acc [AXIS_COUNT]
);

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic [DATA_W-1:0] coef [MAT_ENTRIES];

  logic              c_valid;
  ftsc_tag_t         c_tag;
  logic [PROD_W-1:0] b_prod [MAT_ENTRIES];
  logic [PROD_W-1:0] c_prod [MAT_ENTRIES];

  logic              d_valid;
  ftsc_tag_t         d_tag;
  logic [PAIR_W-1:0] c_pair [AXIS_COUNT*PAIRS_PER_ROW];
  logic [PAIR_W-1:0] d_pair [AXIS_COUNT*PAIRS_PER_ROW];

  logic [ACC_W-1:0]  d_acc [AXIS_COUNT];

  logic c_free;
  logic d_free;
  logic e_free;

  assign e_free  = !e_valid || e_ready;
  assign d_free  = !d_valid || e_free;
  assign c_free  = !c_valid || d_free;
  assign b_ready = c_free;

  // matrix is written as the load word leaves stage B, where samples read it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAT_ENTRIES; i++) begin
        coef[i] <= '0;
      end
    end else if (b_valid && c_free && b_mload.we) begin
      coef[b_mload.index] <= b_mload.value;
    end
  end

  for (genvar r = 0; r < AXIS_COUNT; r++) begin : g_row
    for (genvar c = 0; c < AXIS_COUNT; c++) begin : g_col
      assign b_prod[r*AXIS_COUNT+c] =
        {{DATA_W{coef[r*AXIS_COUNT+c][DATA_W-1]}}, coef[r*AXIS_COUNT+c]} *
        {{DATA_W{b_diff[c][DATA_W-1]}}, b_diff[c]};
    end
    for (genvar k = 0; k < PAIRS_PER_ROW; k++) begin : g_pair
      assign c_pair[r*PAIRS_PER_ROW+k] =
        {c_prod[r*AXIS_COUNT+2*k][PROD_W-1], c_prod[r*AXIS_COUNT+2*k]} +
        {c_prod[r*AXIS_COUNT+2*k+1][PROD_W-1], c_prod[r*AXIS_COUNT+2*k+1]};
    end
    assign d_acc[r] =
      {{(ACC_W-PAIR_W){d_pair[r*PAIRS_PER_ROW][PAIR_W-1]}}, d_pair[r*PAIRS_PER_ROW]} +
      {{(ACC_W-PAIR_W){d_pair[r*PAIRS_PER_ROW+1][PAIR_W-1]}}, d_pair[r*PAIRS_PER_ROW+1]} +
      {{(ACC_W-PAIR_W){d_pair[r*PAIRS_PER_ROW+2][PAIR_W-1]}}, d_pair[r*PAIRS_PER_ROW+2]} +
      ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (c_free) c_valid <= b_valid;
      if (d_free) d_valid <= c_valid;
      if (e_free) e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free) begin
      c_tag  <= b_tag;
      c_prod <= b_prod;
    end
    if (d_free) begin
      d_tag  <= c_tag;
      d_pair <= c_pair;
    end
    if (e_free) begin
      e_tag <= d_tag;
      for (int r = 0; r < AXIS_COUNT; r++) begin
        e_acc[r] <= d_acc[r];
      end
    end
  end

  `FTSC_ASSERT_NEXT(a_c_hold, clk, rst, c_valid && !d_free, c_valid && $stable(c_tag), "product stage dropped or changed a stalled word")
  `FTSC_ASSERT_NEXT(a_e_hold, clk, rst, e_valid && !e_ready, e_valid && $stable(e_tag), "sum stage dropped or changed a stalled word")

endmodule

`default_nettype wire

// File: rtl/core/ftsc_round.sv
// ---------------------------------------------------------------------------
// ftsc_round
// Rounding shift, saturation to Q16.16 and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "force_torque_sample_calibrator_macros.svh"

module ftsc_round import ftsc_pkg::*; #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    e_valid,
  output logic                    e_ready,
  input  ftsc_tag_t               e_tag,
  input  logic signed [ACC_W-1:0] e_acc [AXIS_COUNT],
  ftsc_out_if.source              result
);

  logic                     out_free;
  logic signed [ACC_W-1:0]  shifted [AXIS_COUNT];
  logic [ACC_W-DATA_W:0]    upper   [AXIS_COUNT];
  logic signed [DATA_W-1:0] axis    [AXIS_COUNT];

  assign out_free = !result.valid || result.ready;
  assign e_ready  = out_free;

  // rounding offset is already in the sum; shift and clamp to 32 bits
  always_comb begin
    for (int r = 0; r < AXIS_COUNT; r++) begin
      shifted[r] = e_acc[r] >>> COEF_FRAC_BITS;
      upper[r]   = shifted[r][ACC_W-1:DATA_W-1];
      if (!e_tag.sample_ok) begin
        axis[r] = '0;
      end else if (&upper[r] || ~|upper[r]) begin
        axis[r] = shifted[r][DATA_W-1:0];
      end else begin
        axis[r] = shifted[r][ACC_W-1] ? DATA_MIN : DATA_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      result.result_status <= e_tag.status;
      result.device_status <= e_tag.device_status;
      result.axis_out_0    <= axis[0];
      result.axis_out_1    <= axis[1];
      result.axis_out_2    <= axis[2];
      result.axis_out_3    <= axis[3];
      result.axis_out_4    <= axis[4];
      result.axis_out_5    <= axis[5];
    end
  end

  `FTSC_ASSERT_SAME(a_axes_zero, clk, rst, result.valid && result.result_status != RS_OK, result.axis_out_0 == '0 && result.axis_out_3 == '0 && result.axis_out_5 == '0, "axes nonzero on a failed word")
  `FTSC_ASSERT_SAME(a_status_zero, clk, rst, result.valid && (result.result_status == RS_BAD_LEN || result.result_status == RS_BAD_INDEX), result.device_status == '0, "device status set on a bad length or load")

endmodule

`default_nettype wire

// File: rtl/core/force_torque_sample_calibrator.sv
// ---------------------------------------------------------------------------
// Force/torque sample calibrator top level.
// A result word passes stage registers A, B, C, D, E and the output register after its input word is accepted.
// Throughput: one word per cycle while result.ready holds; the 36 parallel 32x32 multipliers set the stage depth.
// A stall holds every stage in place; bubbles ahead of a stall are filled.
// Reset is synchronous; it empties the pipeline and clears matrix and bias to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module force_torque_sample_calibrator import ftsc_pkg::*; #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  ftsc_in_if.sink     item,
  ftsc_out_if.source  result
);

  logic                     b_valid;
  logic                     b_ready;
  ftsc_tag_t                b_tag;
  logic signed [DATA_W-1:0] b_diff [AXIS_COUNT];
  ftsc_mload_t              b_mload;

  logic                     e_valid;
  logic                     e_ready;
  ftsc_tag_t                e_tag;
  logic signed [ACC_W-1:0]  e_acc [AXIS_COUNT];

  ftsc_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .b_valid (b_valid),
    .b_ready (b_ready),
    .b_tag   (b_tag),
    .b_diff  (b_diff),
    .b_mload (b_mload)
  );

  ftsc_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .b_valid (b_valid),
    .b_ready (b_ready),
    .b_tag   (b_tag),
    .b_diff  (b_diff),
    .b_mload (b_mload),
    .e_valid (e_valid),
    .e_ready (e_ready),
    .e_tag   (e_tag),
    .e_acc   (e_acc)
  );

  ftsc_round #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_round (
    .clk     (clk),
    .rst     (rst),
    .e_valid (e_valid),
    .e_ready (e_ready),
    .e_tag   (e_tag),
    .e_acc   (e_acc),
    .result  (result)
  );

endmodule

`default_nettype wire
